@@ rtl/sha1md_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Shared types, constants and small functions for the SHA-1 digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    localparam int WORD_W       = 32;
    localparam int BLOCK_WORDS  = 16;
    localparam int DIGEST_WORDS = 5;
    localparam int COUNT_W      = 61;
    localparam int RND_W        = 7;

    localparam logic [RND_W-1:0] LAST_ROUND    = 7'd79;
    localparam logic [7:0]       PAD_BYTE      = 8'h80;
    localparam logic [3:0]       LEN_HI_IDX    = 4'd14;
    localparam logic [3:0]       LEN_LO_IDX    = 4'd15;
    localparam logic [4:0]       ONE_BLK_LIMIT = 5'd14;
    localparam logic [4:0]       TWO_BLK_LIMIT = 5'd16;
    localparam logic [2:0]       LAST_WORD_IDX = 3'd4;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [DIGEST_WORDS-1:0][WORD_W-1:0] chain_t;

    // Write into the message block store.
    typedef struct packed {
        logic       en;
        logic       keep;   // OR into the existing word rather than overwrite
        logic [3:0] idx;
        word_t      data;
    } blk_wr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BLOCK,
        ST_PAD,
        ST_ZERO,
        ST_COMP1,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_COMP2,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_ADD
    } core_state_t;

    function automatic word_t init_value(input logic [2:0] idx);
        word_t v;
        case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            default: v = 32'hC3D2E1F0;
        endcase
        return v;
    endfunction

    function automatic word_t round_k(input logic [RND_W-1:0] rnd);
        word_t k;
        if (rnd < 7'd20)
            k = 32'h5A827999;
        else if (rnd < 7'd40)
            k = 32'h6ED9EBA1;
        else if (rnd < 7'd60)
            k = 32'h8F1BBCDC;
        else
            k = 32'hCA62C1D6;
        return k;
    endfunction

    function automatic word_t round_f(input logic [RND_W-1:0] rnd,
                                      input word_t b, input word_t c, input word_t d);
        word_t f;
        if (rnd < 7'd20)
            f = (b & c) | (~b & d);
        else if (rnd >= 7'd40 && rnd < 7'd60)
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

    // Places a byte in its big-endian lane of a word.
    function automatic word_t byte_lane(input logic [7:0] b, input logic [1:0] lane);
        word_t w;
        case (lane)
            2'd0:    w = {b, 24'h000000};
            2'd1:    w = {8'h00, b, 16'h0000};
            2'd2:    w = {16'h0000, b, 8'h00};
            default: w = {24'h000000, b};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/sha1md_core.sv @@
// ----------------------------------------------------------------------------
// SHA-1 compression core
// Holds the 16-word message block and the chaining value, and runs one
// SHA-1 round per cycle through a single shared round unit.
// ----------------------------------------------------------------------------
module sha1md_core (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1md_pkg::blk_wr_t wr,
    input  logic                go,
    input  logic                chain_init,
    output logic                done,
    output sha1md_pkg::chain_t  chain
);

    sha1md_pkg::core_state_t state_reg, state_next;
    sha1md_pkg::word_t       w_reg [sha1md_pkg::BLOCK_WORDS];
    sha1md_pkg::word_t       w_next [sha1md_pkg::BLOCK_WORDS];
    sha1md_pkg::word_t       a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1md_pkg::word_t       a_next, b_next, c_next, d_next, e_next;
    logic [sha1md_pkg::RND_W-1:0] rnd_reg, rnd_next;
    sha1md_pkg::chain_t      chain_reg, chain_next;
    sha1md_pkg::word_t       w_mix, w_cur, temp;
    logic                    load, run, add;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha1md_pkg::CORE_IDLE:
            begin
                if (go)
                    state_next = sha1md_pkg::CORE_ROUND;
            end
            sha1md_pkg::CORE_ROUND:
            begin
                if (rnd_reg == sha1md_pkg::LAST_ROUND)
                    state_next = sha1md_pkg::CORE_ADD;
            end
            sha1md_pkg::CORE_ADD:
            begin
                state_next = sha1md_pkg::CORE_IDLE;
            end
            default:
            begin
                state_next = sha1md_pkg::CORE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load = 1'b0;
        run  = 1'b0;
        add  = 1'b0;
        case (state_reg)
            sha1md_pkg::CORE_IDLE:  load = go;
            sha1md_pkg::CORE_ROUND: run  = 1'b1;
            sha1md_pkg::CORE_ADD:   add  = 1'b1;
            default:                load = 1'b0;
        endcase
    end

    assign done  = add;
    assign chain = chain_reg;

    // The block store shifts down one word per round, so the schedule taps
    // always sit at fixed slots: slot 0 is w[t-16], slot 2 w[t-14] and so on.
    // After 80 rounds the slots line up with the word indexes again.
    assign w_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign w_cur = (rnd_reg < 7'd16) ? w_reg[0] : {w_mix[30:0], w_mix[31]};
    assign temp  = {a_reg[26:0], a_reg[31:27]}
                 + sha1md_pkg::round_f(rnd_reg, b_reg, c_reg, d_reg)
                 + e_reg + sha1md_pkg::round_k(rnd_reg) + w_cur;

    always_comb
    begin
        for (int i = 0; i < sha1md_pkg::BLOCK_WORDS; i++)
            w_next[i] = w_reg[i];
        if (run)
        begin
            for (int i = 0; i < sha1md_pkg::BLOCK_WORDS - 1; i++)
                w_next[i] = w_reg[i+1];
            w_next[sha1md_pkg::BLOCK_WORDS-1] = w_cur;
        end
        else if (wr.en)
        begin
            w_next[wr.idx] = wr.keep ? (w_reg[wr.idx] | wr.data) : wr.data;
        end
    end

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        c_next   = c_reg;
        d_next   = d_reg;
        e_next   = e_reg;
        rnd_next = rnd_reg;
        if (load)
        begin
            a_next   = chain_reg[0];
            b_next   = chain_reg[1];
            c_next   = chain_reg[2];
            d_next   = chain_reg[3];
            e_next   = chain_reg[4];
            rnd_next = '0;
        end
        else if (run)
        begin
            a_next   = temp;
            b_next   = a_reg;
            c_next   = {b_reg[1:0], b_reg[31:2]};
            d_next   = c_reg;
            e_next   = d_reg;
            rnd_next = rnd_reg + 7'd1;
        end
    end

    always_comb
    begin
        chain_next = chain_reg;
        if (chain_init)
        begin
            for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++)
                chain_next[i] = sha1md_pkg::init_value(3'(i));
        end
        else if (add)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1md_pkg::CORE_IDLE;
            rnd_reg   <= '0;
            for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++)
                chain_reg[i] <= sha1md_pkg::init_value(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < sha1md_pkg::BLOCK_WORDS; i++)
            w_reg[i] <= w_next[i];
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

endmodule

@@ rtl/sha1_message_digest.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Byte-serial SHA-1 hash with padding and five-word digest output.
// ----------------------------------------------------------------------------
// Usage: present one beat per message byte on data_byte with byte_present
// high, and raise end_of_message on the final beat; the final beat may carry
// no byte, so an empty message is a single beat with only end_of_message.
// A beat is taken at a rising edge where start is high and busy is low.
// A byte that does not complete a 64-byte block and carries no end mark
// leaves busy low. The byte that completes a block keeps busy high while the
// round unit runs its 80 rounds, one per cycle, then adds into the chaining
// value. After the end mark the block pads the message with word writes,
// runs one or two compressions, and then shows the digest as five beats on
// consecutive cycles, H0 first, each marked by digest_valid for one cycle;
// last_word flags H4. The result side has no back-pressure. Reset returns
// the chaining value and byte count to their initial state; the message
// block store is not cleared. After the fifth digest beat the block is
// ready for the next message.
// ----------------------------------------------------------------------------
module sha1_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        digest_valid,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha1md_pkg::ctrl_state_t state_reg, state_next;
    logic [sha1md_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [4:0]  widx_reg, widx_next;
    logic        two_blk_reg, two_blk_next;
    logic        fin_reg, fin_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        valid_reg, valid_next;
    sha1md_pkg::word_t word_reg, word_next;
    logic [2:0]  index_reg, index_next;
    logic        last_reg, last_next;

    sha1md_pkg::blk_wr_t wr;
    logic        core_go, core_done, chain_init;
    sha1md_pkg::chain_t  chain;
    logic        accept;
    logic [5:0]  pos;
    logic [4:0]  limit;

    assign busy   = (state_reg != sha1md_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign pos    = count_reg[5:0];
    assign limit  = two_blk_reg ? sha1md_pkg::TWO_BLK_LIMIT : sha1md_pkg::ONE_BLK_LIMIT;

    sha1md_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .go         (core_go),
        .chain_init (chain_init),
        .done       (core_done),
        .chain      (chain)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha1md_pkg::ST_IDLE:
            begin
                if (accept && byte_present && (pos == 6'd63))
                    state_next = sha1md_pkg::ST_BLOCK;
                else if (accept && end_of_message)
                    state_next = sha1md_pkg::ST_PAD;
            end
            sha1md_pkg::ST_BLOCK:
            begin
                if (core_done)
                    state_next = fin_reg ? sha1md_pkg::ST_PAD : sha1md_pkg::ST_IDLE;
            end
            sha1md_pkg::ST_PAD:
            begin
                state_next = sha1md_pkg::ST_ZERO;
            end
            sha1md_pkg::ST_ZERO:
            begin
                if (widx_reg == limit)
                    state_next = two_blk_reg ? sha1md_pkg::ST_COMP1 : sha1md_pkg::ST_LEN_HI;
            end
            sha1md_pkg::ST_COMP1:
            begin
                if (core_done)
                    state_next = sha1md_pkg::ST_ZERO;
            end
            sha1md_pkg::ST_LEN_HI:
            begin
                state_next = sha1md_pkg::ST_LEN_LO;
            end
            sha1md_pkg::ST_LEN_LO:
            begin
                state_next = sha1md_pkg::ST_COMP2;
            end
            sha1md_pkg::ST_COMP2:
            begin
                if (core_done)
                    state_next = sha1md_pkg::ST_OUT;
            end
            sha1md_pkg::ST_OUT:
            begin
                if (oidx_reg == sha1md_pkg::LAST_WORD_IDX)
                    state_next = sha1md_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sha1md_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr           = '0;
        core_go      = 1'b0;
        chain_init   = 1'b0;
        count_next   = count_reg;
        widx_next    = widx_reg;
        two_blk_next = two_blk_reg;
        fin_next     = fin_reg;
        oidx_next    = oidx_reg;
        valid_next   = 1'b0;
        word_next    = word_reg;
        index_next   = index_reg;
        last_next    = last_reg;
        case (state_reg)
            sha1md_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    fin_next = end_of_message;
                    if (byte_present)
                    begin
                        wr.en      = 1'b1;
                        wr.keep    = (pos[1:0] != 2'd0);
                        wr.idx     = pos[5:2];
                        wr.data    = sha1md_pkg::byte_lane(data_byte, pos[1:0]);
                        count_next = count_reg + 61'd1;
                        core_go    = (pos == 6'd63);
                    end
                end
            end
            sha1md_pkg::ST_PAD:
            begin
                // The rest of this word is already zero: its first byte
                // overwrote the whole word earlier in this block.
                wr.en        = 1'b1;
                wr.keep      = (pos[1:0] != 2'd0);
                wr.idx       = pos[5:2];
                wr.data      = sha1md_pkg::byte_lane(sha1md_pkg::PAD_BYTE, pos[1:0]);
                widx_next    = {1'b0, pos[5:2]} + 5'd1;
                two_blk_next = (pos[5:3] == 3'b111);
            end
            sha1md_pkg::ST_ZERO:
            begin
                if (widx_reg == limit)
                begin
                    core_go = two_blk_reg;
                end
                else
                begin
                    wr.en     = 1'b1;
                    wr.idx    = widx_reg[3:0];
                    widx_next = widx_reg + 5'd1;
                end
            end
            sha1md_pkg::ST_COMP1:
            begin
                if (core_done)
                begin
                    widx_next    = '0;
                    two_blk_next = 1'b0;
                end
            end
            sha1md_pkg::ST_LEN_HI:
            begin
                wr.en   = 1'b1;
                wr.idx  = sha1md_pkg::LEN_HI_IDX;
                wr.data = count_reg[60:29];
            end
            sha1md_pkg::ST_LEN_LO:
            begin
                wr.en   = 1'b1;
                wr.idx  = sha1md_pkg::LEN_LO_IDX;
                wr.data = {count_reg[28:0], 3'b000};
                core_go = 1'b1;
            end
            sha1md_pkg::ST_COMP2:
            begin
                oidx_next = '0;
            end
            sha1md_pkg::ST_OUT:
            begin
                valid_next = 1'b1;
                word_next  = chain[oidx_reg];
                index_next = oidx_reg;
                last_next  = (oidx_reg == sha1md_pkg::LAST_WORD_IDX);
                oidx_next  = oidx_reg + 3'd1;
                if (oidx_reg == sha1md_pkg::LAST_WORD_IDX)
                begin
                    chain_init = 1'b1;
                    count_next = '0;
                end
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sha1md_pkg::ST_IDLE;
            count_reg   <= '0;
            widx_reg    <= '0;
            two_blk_reg <= 1'b0;
            fin_reg     <= 1'b0;
            oidx_reg    <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            widx_reg    <= widx_next;
            two_blk_reg <= two_blk_next;
            fin_reg     <= fin_next;
            oidx_reg    <= oidx_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        index_reg <= index_next;
        last_reg  <= last_next;
    end

    assign digest_valid = valid_reg;
    assign digest_word  = word_reg;
    assign word_index   = index_reg;
    assign last_word    = last_reg;

endmodule

@@ rtl/sha1md_checker.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message digest port checker
// Watches the top-level ports for the digest beat sequence and handshake.
// ----------------------------------------------------------------------------
module sha1md_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        end_of_message,
    input logic        digest_valid,
    input logic [2:0]  word_index,
    input logic        last_word
);

    // The final digest beat is always H4.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && last_word |-> word_index == sha1md_pkg::LAST_WORD_IDX)
        else $error("last_word raised on a beat other than H4");

    // Digest beats come back to back with rising word indexes.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !last_word |=> digest_valid && word_index == $past(word_index) + 3'd1)
        else $error("digest beats not consecutive");

    // A digest sequence never starts part-way through.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && word_index != 3'd0 |-> $past(digest_valid))
        else $error("digest beat without its predecessor");

    // An end-of-message beat always leads to work, so the block goes busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && end_of_message |=> busy)
        else $error("end of message taken without going busy");

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Streams byte messages into the digest block, predicts every digest word
// with its own SHA-1 and padding model, and checks each digest beat in order.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       eom;
        bit         steady;     // no random gap in front of this beat
    } msg_beat_t;

    typedef struct {
        sha1md_pkg::word_t word;
        logic [2:0]        idx;
        logic              last;
    } digest_beat_t;

    localparam sha1md_pkg::word_t SHA1_IV [sha1md_pkg::DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic [7:0]  data_byte      = 8'h00;
    logic        byte_present   = 1'b0;
    logic        end_of_message = 1'b0;
    logic        digest_valid;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    msg_beat_t    pending_beats [$];
    digest_beat_t expected_digest [$];

    sha1md_pkg::word_t msg_block [sha1md_pkg::BLOCK_WORDS];
    sha1md_pkg::word_t hash_state [sha1md_pkg::DIGEST_WORDS];
    logic [60:0]       byte_count;

    int mismatch_count  = 0;
    int queued_beats    = 0;

    sha1_message_digest DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .digest_valid   (digest_valid),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Digest predictor
    // ------------------------------------------------------------------
    function automatic sha1md_pkg::word_t rotl(input sha1md_pkg::word_t x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_digest();
        for (int i = 0; i < sha1md_pkg::BLOCK_WORDS; i++)
            msg_block[i] = '0;
        for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++)
            hash_state[i] = SHA1_IV[i];
        byte_count = '0;
    endfunction

    function automatic void sha1_compress();
        sha1md_pkg::word_t sched [16];
        sha1md_pkg::word_t a, b, c, d, e, f, k, t, wt;
        for (int r = 0; r < 16; r++)
            sched[r] = msg_block[r];
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 16)
                wt = sched[r];
            else
            begin
                wt = rotl(sched[(r + 13) % 16] ^ sched[(r + 8) % 16] ^
                          sched[(r + 2) % 16] ^ sched[r % 16], 1);
                sched[r % 16] = wt;
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rotl(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    // The first byte of a word overwrites it, so stale words never leak in.
    function automatic void place_byte(input int pos, input logic [7:0] value);
        sha1md_pkg::word_t lane;
        lane = sha1md_pkg::word_t'(value) << ((3 - (pos % 4)) * 8);
        if (pos % 4 == 0)
            msg_block[pos / 4] = lane;
        else
            msg_block[pos / 4] |= lane;
    endfunction

    function automatic void predict_digest(input logic [7:0] value,
                                           input logic present, input logic eom);
        int          pos;
        logic [63:0] bit_len;
        if (present)
        begin
            pos = int'(byte_count[5:0]);
            place_byte(pos, value);
            byte_count = byte_count + 61'd1;
            if (pos == 63)
                sha1_compress();
        end
        if (eom)
        begin
            bit_len = {byte_count, 3'b000};
            pos = int'(byte_count[5:0]);
            place_byte(pos, 8'h80);
            pos++;
            // No room left for the length field: finish this block first.
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    place_byte(pos, 8'h00);
                    pos++;
                end
                sha1_compress();
                pos = 0;
            end
            while (pos < 56)
            begin
                place_byte(pos, 8'h00);
                pos++;
            end
            msg_block[14] = bit_len[63:32];
            msg_block[15] = bit_len[31:0];
            sha1_compress();
            for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++)
                expected_digest.push_back('{hash_state[i], 3'(i),
                                            i == sha1md_pkg::DIGEST_WORDS - 1});
            restart_digest();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_beat(input logic [7:0] value, input logic present,
                                      input logic eom, input bit steady);
        pending_beats.push_back('{value, present, eom, steady});
        if (present || eom)
            queued_beats++;
    endfunction

    // A message of len bytes with random content and the odd ignored beat.
    // The end mark rides on the last byte or follows on a beat of its own.
    function automatic void queue_message(input int len, input bit steady);
        bit end_on_byte;
        end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 5)
                push_beat(8'($urandom), 1'b0, 1'b0, steady);
            push_beat(8'($urandom_range(0, 255)), 1'b1,
                      end_on_byte && (i == len - 1), steady);
        end
        if (!end_on_byte)
            push_beat(8'($urandom), 1'b0, 1'b1, steady);
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : beat_driver
        msg_beat_t next_beat;
        logic      advance;
        if (!rst_n)
        begin
            start          <= 1'b0;
            data_byte      <= 8'h00;
            byte_present   <= 1'b0;
            end_of_message <= 1'b0;
            restart_digest();
        end
        else
        begin
            advance = !start;
            if (start && !busy)
            begin
                predict_digest(data_byte, byte_present, end_of_message);
                advance = 1'b1;
            end
            if (advance)
            begin
                if (pending_beats.size() != 0 &&
                    (pending_beats[0].steady || $urandom_range(0, 99) >= 11))
                begin
                    next_beat = pending_beats.pop_front();
                    start          <= 1'b1;
                    data_byte      <= next_beat.data;
                    byte_present   <= next_beat.present;
                    end_of_message <= next_beat.eom;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : digest_monitor
        digest_beat_t want;
        if (rst_n && digest_valid === 1'b1)
        begin
            if (expected_digest.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Digest beat with nothing expected: word %h idx %0d last %b",
                             digest_word, word_index, last_word);
            end
            else
            begin
                want = expected_digest.pop_front();
                if (digest_word !== want.word || word_index !== want.idx ||
                    last_word !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                                 want.word, want.idx, want.last,
                                 digest_word, word_index, last_word);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    // Checked on the falling edge, when the driver's updates have settled.
    task automatic wait_all_digested();
        while (pending_beats.size() != 0 || start)
            @(negedge clk);
        while (expected_digest.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : test_sequence
        int len;
        int pick;
        // Empty message, with junk on the data lines.
        push_beat(8'hA5, 1'b0, 1'b1, 1'b0);
        // A beat with neither byte nor end mark must be ignored.
        push_beat(8'hFF, 1'b0, 1'b0, 1'b0);
        push_beat(8'h00, 1'b1, 1'b1, 1'b0);
        push_beat(8'h61, 1'b1, 1'b0, 1'b0);
        push_beat(8'h62, 1'b1, 1'b0, 1'b0);
        push_beat(8'h63, 1'b1, 1'b1, 1'b0);
        // The end mark arrives on a beat with no byte.
        push_beat(8'hFF, 1'b1, 1'b0, 1'b0);
        push_beat(8'h80, 1'b1, 1'b0, 1'b0);
        push_beat(8'h7E, 1'b0, 1'b1, 1'b0);
        push_beat(8'h00, 1'b0, 1'b0, 1'b0);
        push_beat(8'hFF, 1'b1, 1'b1, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Hold the sender back until every digest word has come out.
        wait_all_digested();

        queued_beats = 0;
        // 55 bytes still pads in one block, 56 needs a second one.
        // The 56-byte message goes out with no gaps from the sender.
        queue_message(55, 1'b0);
        queue_message(56, 1'b1);
        while (queued_beats < 259)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                len = $urandom_range(0, 9);
            else if (pick < 9)
                len = $urandom_range(60, 66);
            else
                len = $urandom_range(115, 130);
            if (len > 259 - queued_beats)
                len = 259 - queued_beats;
            queue_message(len, 1'b0);
        end

        wait_all_digested();
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #1600000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ sha1_message_digest.f @@
rtl/sha1md_pkg.sv
rtl/sha1md_core.sv
rtl/sha1_message_digest.sv
rtl/sha1md_checker.sv
tb/sv/tb.sv
